// ===== design/assert_macros.svh =====
// Assertion macros used by the port-level checker of the transmit framer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define AHTX_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property checked at every rising edge, reset included.
`define AHTX_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/ahtx_pkg.sv =====
// Types and constants of the async HDLC transmit byte stuffer.
`timescale 1ns / 1ps

package ahtx_pkg;

  localparam int FRAME_SIZE  = 4096;
  localparam int SIZE_MARGIN = 10;
  localparam int MAX_RES     = 5;
  localparam int LC_W        = $clog2(FRAME_SIZE) + 1;
  localparam int CNT_W       = $clog2(MAX_RES + 1);
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;

  typedef logic [LC_W-1:0]      lc_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam lc_t SIZE_LIMIT = lc_t'(FRAME_SIZE - SIZE_MARGIN);

  localparam logic [7:0] LINE_FLAG  = 8'h7E;
  localparam logic [7:0] LINE_ESC   = 8'h7D;
  localparam logic [7:0] ESC_XOR    = 8'h20;
  localparam logic [7:0] CTRL_LIMIT = 8'h20;

  // Configuration register indexes
  localparam cfg_idx_t CFG_TX_ACCM  = 3'd0;
  localparam cfg_idx_t CFG_MAP_EN   = 3'd1;
  localparam cfg_idx_t CFG_MAP_0    = 3'd2;
  localparam cfg_idx_t CFG_MAP_1    = 3'd3;
  localparam cfg_idx_t CFG_MAP_2    = 3'd4;
  localparam cfg_idx_t CFG_MAP_3    = 3'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
    logic       lcp_frame;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_aborted;
    logic       end_of_item;
  } out_item_t;

  typedef out_item_t [MAX_RES-1:0] burst_t;

  // Encoded results of one request and how many of them are valid.
  typedef struct packed {
    burst_t items;
    cnt_t   count;
  } enc_t;

  typedef struct packed {
    logic [31:0]  tx_accm;
    logic         escape_map_enable;
    logic [255:0] escape_map;
  } cfg_t;

endpackage

// ===== design/ahtx_cfg_regs.sv =====
// Configuration registers of the transmit framer.
`timescale 1ns / 1ps

module ahtx_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  ahtx_pkg::cfg_idx_t          cfg_index,
  input  logic [ahtx_pkg::CFG_DATA_W-1:0] cfg_data,
  output ahtx_pkg::cfg_t              cfg
);

  ahtx_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tx_accm           <= 32'hFFFF_FFFF;
      cfg_r.escape_map_enable <= 1'b0;
      cfg_r.escape_map        <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ahtx_pkg::CFG_TX_ACCM: cfg_r.tx_accm           <= cfg_data[31:0];
        ahtx_pkg::CFG_MAP_EN:  cfg_r.escape_map_enable <= cfg_data[0];
        ahtx_pkg::CFG_MAP_0:   cfg_r.escape_map[63:0]    <= cfg_data;
        ahtx_pkg::CFG_MAP_1:   cfg_r.escape_map[127:64]  <= cfg_data;
        ahtx_pkg::CFG_MAP_2:   cfg_r.escape_map[191:128] <= cfg_data;
        ahtx_pkg::CFG_MAP_3:   cfg_r.escape_map[255:192] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== design/ahtx_encoder.sv =====
// Frame state and byte-stuffing encoder: turns one request into its line bytes.
`timescale 1ns / 1ps

module ahtx_encoder (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  ahtx_pkg::in_item_t   item,
  input  ahtx_pkg::cfg_t       cfg,
  output ahtx_pkg::enc_t       enc
);

  logic           in_frame_r, in_frame_nxt;
  ahtx_pkg::lc_t  line_count_r, line_count_nxt;

  logic           open_frame;
  logic           esc1, esc2, over;
  logic [7:0]     c0, c1, c2;
  ahtx_pkg::lc_t  base, total;
  ahtx_pkg::cnt_t pos;
  ahtx_pkg::burst_t items;

  always_comb begin
    c0         = item.data_byte;
    open_frame = in_frame_r | item.first_byte;

    esc1 = ((c0 < ahtx_pkg::CTRL_LIMIT) && (item.lcp_frame || cfg.tx_accm[c0[4:0]]))
           || (c0 == ahtx_pkg::LINE_ESC) || (c0 == ahtx_pkg::LINE_FLAG);
    c1   = esc1 ? (c0 ^ ahtx_pkg::ESC_XOR) : c0;
    // The extra map looks at the byte after the first escape, if any.
    esc2 = cfg.escape_map_enable && cfg.escape_map[c1];
    c2   = esc2 ? (c1 ^ ahtx_pkg::ESC_XOR) : c1;

    base  = item.first_byte ? ahtx_pkg::lc_t'(1) : line_count_r;
    total = base + ahtx_pkg::lc_t'(esc1) + ahtx_pkg::lc_t'(esc2) + ahtx_pkg::lc_t'(1);
    over  = (total >= ahtx_pkg::SIZE_LIMIT);

    items = '0;
    pos   = '0;
    if (item.first_byte) begin
      items[pos].out_byte = ahtx_pkg::LINE_FLAG;
      pos = pos + ahtx_pkg::cnt_t'(1);
    end
    if (open_frame) begin
      if (esc1) begin
        items[pos].out_byte = ahtx_pkg::LINE_ESC;
        pos = pos + ahtx_pkg::cnt_t'(1);
      end
      if (esc2) begin
        items[pos].out_byte = ahtx_pkg::LINE_ESC;
        pos = pos + ahtx_pkg::cnt_t'(1);
      end
      items[pos].out_byte = c2;
      pos = pos + ahtx_pkg::cnt_t'(1);
      if (over) begin
        items[pos].frame_aborted = 1'b1;
        pos = pos + ahtx_pkg::cnt_t'(1);
      end else if (item.last_byte) begin
        items[pos].out_byte = ahtx_pkg::LINE_FLAG;
        pos = pos + ahtx_pkg::cnt_t'(1);
      end
    end
    for (int k = 0; k < ahtx_pkg::MAX_RES; k++) begin
      items[k].end_of_item = (ahtx_pkg::cnt_t'(k + 1) == pos);
    end

    enc.items = items;
    enc.count = pos;

    in_frame_nxt   = in_frame_r;
    line_count_nxt = line_count_r;
    if (open_frame) begin
      if (over || item.last_byte) begin
        in_frame_nxt   = 1'b0;
        line_count_nxt = '0;
      end else begin
        in_frame_nxt   = 1'b1;
        line_count_nxt = total;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r   <= 1'b0;
      line_count_r <= '0;
    end else if (accept) begin
      in_frame_r   <= in_frame_nxt;
      line_count_r <= line_count_nxt;
    end
  end

endmodule

// ===== design/ahtx_burst.sv =====
// Burst buffer: moves encoded line bytes one per cycle to the output register if free.
`timescale 1ns / 1ps

module ahtx_burst (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  ahtx_pkg::enc_t      enc,
  output logic                can_load,
  output logic                out_valid,
  input  logic                out_stall,
  output ahtx_pkg::out_item_t out_data
);

  ahtx_pkg::burst_t    buf_r;
  ahtx_pkg::cnt_t      rem_r;
  logic                out_valid_r;
  ahtx_pkg::out_item_t out_data_r;

  logic out_free, move;

  assign out_free = !out_valid_r || !out_stall;
  assign move     = (rem_r != '0) && out_free;
  // A new request may enter as soon as the last buffered byte leaves.
  assign can_load = (rem_r == '0) || ((rem_r == ahtx_pkg::cnt_t'(1)) && out_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else if (load) begin
      rem_r <= enc.count;
    end else if (move) begin
      rem_r <= rem_r - ahtx_pkg::cnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buf_r <= enc.items;
    end else if (move) begin
      for (int k = 0; k < ahtx_pkg::MAX_RES - 1; k++) begin
        buf_r[k] <= buf_r[k+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (move) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_data_r <= buf_r[0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/async_hdlc_tx_byte_stuffer.sv =====
// Top level of the async HDLC transmit byte stuffer.
// Input channel: one payload byte per request with first, last and LCP flags,
// taken when in_valid is high and in_stall is low. Output channel: one line
// byte per transfer, in order, with an abort marker and an end-of-item marker.
// A request is encoded in the cycle it is accepted and its line bytes (none to
// five) are loaded into a burst buffer; its first line byte then passes from the
// buffer into the output register. The output register sends one line byte per
// cycle while the receiver does not stall, with the burst buffer draining into it.
// A new request is taken in the cycle the last byte of the previous one moves to
// the output register, even while that byte is still stalled there.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user must
// do so only while idle, which the block itself does not enforce.
// Synchronous reset closes any open frame, empties the buffer and restores the
// register defaults. When the receiver stalls, the output holds its byte and
// the buffer keeps its bytes; in_stall is high whenever the buffer cannot
// take a new request.
`timescale 1ns / 1ps

module async_hdlc_tx_byte_stuffer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  ahtx_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output ahtx_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  ahtx_pkg::cfg_idx_t              cfg_index,
  input  logic [ahtx_pkg::CFG_DATA_W-1:0] cfg_data
);

  ahtx_pkg::cfg_t cfg;
  ahtx_pkg::enc_t enc;
  logic           can_load;
  logic           accept;

  assign in_stall = !can_load;
  assign accept   = in_valid && can_load;

  ahtx_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ahtx_encoder u_enc (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (in_data),
    .cfg    (cfg),
    .enc    (enc)
  );

  ahtx_burst u_burst (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .enc       (enc),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== design/ahtx_checker.sv =====
// Port-level checker for the transmit framer, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ahtx_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_stall,
  input ahtx_pkg::out_item_t             out_data
);

  `AHTX_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled result changed")
  `AHTX_ASSERT(a_abort_ends, clk, rst_n, out_valid && out_data.frame_aborted |-> out_data.end_of_item && (out_data.out_byte == 8'h00), "abort result is not a final zero byte")
  `AHTX_ASSERT(a_burst_runs, clk, rst_n, out_valid && !out_stall && !out_data.end_of_item |=> out_valid, "request cut short on the output")
  `AHTX_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind async_hdlc_tx_byte_stuffer ahtx_checker u_ahtx_checker (.*);

// ===== tb/ahtx_stuffing_checker.sv =====
// Checker that predicts and compares the line bytes of the async HDLC transmit byte stuffer.
`timescale 1ns / 1ps

module ahtx_stuffing_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  ahtx_pkg::in_item_t              in_data,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  ahtx_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  ahtx_pkg::cfg_idx_t              cfg_index,
  input  logic [ahtx_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              pending
);

  import ahtx_pkg::*;

  localparam int LINE_LIMIT = FRAME_SIZE - SIZE_MARGIN;
  localparam int MAX_PRINTED = 40;

  logic [31:0]  tx_accm;
  logic         map_on;
  logic [255:0] escape_map;
  logic         frame_open;
  int           line_count;
  out_item_t    expected_line[$];

  task automatic report_error(input string msg);
    fail_count++;
    if (fail_count <= MAX_PRINTED) $display("[%0t] stuffing checker: %s", $time, msg);
  endtask

  function automatic out_item_t line_item(input logic [7:0] b, input logic abort);
    out_item_t r;
    r.out_byte      = b;
    r.frame_aborted = abort;
    r.end_of_item   = 1'b0;
    return r;
  endfunction

  // Works out the line bytes that one accepted request causes and queues them.
  task automatic stuff_request(input in_item_t req);
    logic [7:0] c;
    out_item_t  burst[$];
    out_item_t  tail;
    c = req.data_byte;
    if (req.first_byte) begin
      frame_open = 1'b1;
      line_count = 0;
      burst.push_back(line_item(LINE_FLAG, 1'b0));
    end
    // Outside a frame, or while a frame is being dropped, the request is ignored.
    if (!frame_open) return;
    if ((c < CTRL_LIMIT && (req.lcp_frame || tx_accm[c[4:0]])) ||
        c == LINE_ESC || c == LINE_FLAG) begin
      burst.push_back(line_item(LINE_ESC, 1'b0));
      c = c ^ ESC_XOR;
    end
    // The extra map looks at the byte as it stands after the first escape.
    if (map_on && escape_map[c]) begin
      burst.push_back(line_item(LINE_ESC, 1'b0));
      c = c ^ ESC_XOR;
    end
    burst.push_back(line_item(c, 1'b0));
    line_count += burst.size();
    if (line_count >= LINE_LIMIT) begin
      burst.push_back(line_item(8'h00, 1'b1));
      frame_open = 1'b0;
      line_count = 0;
    end else if (req.last_byte) begin
      burst.push_back(line_item(LINE_FLAG, 1'b0));
      frame_open = 1'b0;
      line_count = 0;
    end
    tail = burst.pop_back();
    tail.end_of_item = 1'b1;
    burst.push_back(tail);
    foreach (burst[i]) expected_line.push_back(burst[i]);
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      tx_accm    = '1;
      map_on     = 1'b0;
      escape_map = '0;
      frame_open = 1'b0;
      line_count = 0;
      expected_line.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_line.size() == 0) begin
          report_error($sformatf("line byte %h arrived with nothing expected",
                                 out_data.out_byte));
        end else begin
          want = expected_line.pop_front();
          if (out_data.out_byte !== want.out_byte)
            report_error($sformatf("out_byte %h, expected %h",
                                   out_data.out_byte, want.out_byte));
          if (out_data.frame_aborted !== want.frame_aborted)
            report_error($sformatf("frame_aborted %b, expected %b (byte %h)",
                                   out_data.frame_aborted, want.frame_aborted,
                                   want.out_byte));
          if (out_data.end_of_item !== want.end_of_item)
            report_error($sformatf("end_of_item %b, expected %b (byte %h)",
                                   out_data.end_of_item, want.end_of_item,
                                   want.out_byte));
        end
      end
      if (in_valid && !in_stall) stuff_request(in_data);
      if (cfg_we) begin
        case (cfg_index)
          CFG_TX_ACCM: tx_accm = cfg_data[31:0];
          CFG_MAP_EN:  map_on = cfg_data[0];
          CFG_MAP_0:   escape_map[63:0] = cfg_data;
          CFG_MAP_1:   escape_map[127:64] = cfg_data;
          CFG_MAP_2:   escape_map[191:128] = cfg_data;
          CFG_MAP_3:   escape_map[255:192] = cfg_data;
          default: ;
        endcase
      end
    end
    pending = expected_line.size();
  end

endmodule

// ===== tb/async_hdlc_tx_byte_stuffer_tb.sv =====
// Stimulus and verdict for the async HDLC transmit byte stuffer.
`timescale 1ns / 1ps

module async_hdlc_tx_byte_stuffer_tb;

  import ahtx_pkg::*;

  localparam int RANDOM_ITEMS  = 290;
  localparam int PHASES        = 6;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 1200000;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we = 1'b0;
  cfg_idx_t              cfg_index = CFG_TX_ACCM;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic quiet_tail = 1'b0;
  logic hold_request = 1'b0;
  int   fail_count;
  int   pending;
  int   cycle_count = 0;
  int   sender_calm = 0;

  async_hdlc_tx_byte_stuffer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ahtx_stuffing_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("async_hdlc_tx_byte_stuffer_tb: done, errors");
    $finish;
  end

  // Receiver: random stall bursts, one long hold-off on request, none at the tail.
  initial begin : receiver
    int   left;
    logic stalling;
    logic held;
    left     = 0;
    stalling = 1'b0;
    held     = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (quiet_tail) begin
        stalling = 1'b0;
      end else if (left > 0) begin
        left--;
      end else begin
        stalling = !stalling;
        if (!stalling && $urandom_range(0, 3) == 0) left = $urandom_range(20, 60);
        else left = $urandom_range(0, 11);
      end
      out_stall <= stalling;
    end
  end

  task automatic sender_pause();
    int len;
    if (quiet_tail) return;
    if (sender_calm > 0) begin
      sender_calm--;
      return;
    end
    if ($urandom_range(0, 3) == 0) begin
      sender_calm = $urandom_range(5, 30);
      return;
    end
    len = $urandom_range(1, 12);
    in_valid <= 1'b0;
    repeat (len) @(posedge clk);
  endtask

  // Offers one request, waits for the edge where it is taken, then may pause the sender.
  task automatic send_item(input logic [7:0] b, input logic first, input logic last,
                           input logic lcp);
    in_item_t req;
    req.data_byte  = b;
    req.first_byte = first;
    req.last_byte  = last;
    req.lcp_frame  = lcp;
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    sender_pause();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input logic [31:0] accm, input logic map_on,
                              input logic [255:0] map);
    cfg_idx_t order[6];
    int       k;
    order = '{CFG_TX_ACCM, CFG_MAP_EN, CFG_MAP_0, CFG_MAP_1, CFG_MAP_2, CFG_MAP_3};
    for (k = 0; k < 6; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= order[k];
      case (order[k])
        CFG_TX_ACCM: cfg_data <= {32'b0, accm};
        CFG_MAP_EN:  cfg_data <= {63'b0, map_on};
        CFG_MAP_0:   cfg_data <= map[63:0];
        CFG_MAP_1:   cfg_data <= map[127:64];
        CFG_MAP_2:   cfg_data <= map[191:128];
        default:     cfg_data <= map[255:192];
      endcase
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [255:0] rand_map();
    logic [255:0] m;
    int           i;
    for (i = 0; i < 8; i++) m[32*i +: 32] = $urandom;
    return m;
  endfunction

  // Leans towards flag, escape and control bytes and the escaped forms of flag and escape.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return LINE_FLAG;
      1:       return LINE_ESC;
      2:       return 8'($urandom_range(0, 31));
      3:       return ($urandom_range(0, 1) == 0) ? (LINE_FLAG ^ ESC_XOR) : (LINE_ESC ^ ESC_XOR);
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_random_frames(input int n);
    int   sent;
    int   len;
    int   k;
    logic lcp;
    logic drop_last;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
        sent++;
      end else begin
        len       = $urandom_range(1, 8);
        lcp       = 1'($urandom);
        // Now and then a frame is left open so that the next first byte cuts it off.
        drop_last = ($urandom_range(0, 7) == 0);
        for (k = 0; k < len; k++) begin
          send_item(pick_byte(), k == 0, (k == len - 1) && !drop_last,
                    ($urandom_range(0, 9) == 0) ? !lcp : lcp);
          sent++;
        end
      end
    end
  endtask

  initial begin : stimulus
    int           k;
    logic [255:0] map;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: every control byte is escaped, the extra map is off.
    send_item(8'h41, 1'b0, 1'b0, 1'b0);
    send_item(8'hFF, 1'b0, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b1, 1'b0);
    send_item(LINE_FLAG, 1'b1, 1'b0, 1'b0);
    send_item(LINE_ESC, 1'b0, 1'b0, 1'b0);
    send_item(8'h1F, 1'b0, 1'b0, 1'b1);
    send_item(8'hFF, 1'b0, 1'b0, 1'b0);
    send_item(8'h20, 1'b0, 1'b0, 1'b0);
    send_item(8'h5E, 1'b0, 1'b1, 1'b0);
    // A first byte inside an open frame starts a new one.
    send_item(8'h11, 1'b1, 1'b0, 1'b0);
    send_item(8'h22, 1'b1, 1'b0, 1'b1);
    send_item(8'h80, 1'b0, 1'b1, 1'b0);
    drain();

    map = '0;
    map[LINE_ESC ^ ESC_XOR] = 1'b1;
    map[8'h01] = 1'b1;
    map[8'hFF] = 1'b1;
    write_config(32'h0, 1'b1, map);
    // The escape byte is escaped twice here, giving five line bytes.
    send_item(LINE_ESC, 1'b1, 1'b1, 1'b0);
    send_item(8'h01, 1'b1, 1'b0, 1'b0);
    send_item(8'h01, 1'b0, 1'b0, 1'b1);
    send_item(8'h05, 1'b0, 1'b0, 1'b0);
    send_item(8'hFF, 1'b0, 1'b0, 1'b0);
    send_item(LINE_FLAG, 1'b0, 1'b1, 1'b1);
    send_item(8'h00, 1'b0, 1'b0, 1'b0);

    for (k = 0; k < PHASES; k++) begin
      drain();
      case (k)
        0:       write_config('1, 1'b0, '0);
        1:       write_config('0, 1'b1, '1);
        2:       write_config($urandom, 1'b1, rand_map());
        3:       write_config($urandom, 1'b0, rand_map());
        4:       write_config('0, 1'b1, '0);
        default: write_config($urandom, 1'b1, rand_map() & rand_map());
      endcase
      if (k == 2) begin
        // The receiver holds off while requests keep coming, so the buffer fills.
        hold_request <= 1'b1;
        sender_calm = 60;
      end
      if (k == PHASES - 1) quiet_tail <= 1'b1;
      send_random_frames(RANDOM_ITEMS / PHASES);
    end
    drain();

    if (fail_count == 0 && pending == 0) begin
      $display("async_hdlc_tx_byte_stuffer_tb: done, clean");
    end else begin
      $display("async_hdlc_tx_byte_stuffer_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/ahtx_pkg.sv
design/ahtx_cfg_regs.sv
design/ahtx_encoder.sv
design/ahtx_burst.sv
design/async_hdlc_tx_byte_stuffer.sv
design/ahtx_checker.sv
tb/ahtx_stuffing_checker.sv
tb/async_hdlc_tx_byte_stuffer_tb.sv
